FILE: rtl/rvcx_pkg.sv
// ----------------------------------------------------------------------------
// rvcx_pkg
// Shared types, opcodes and field packers for the RV64C instruction expander.
// ----------------------------------------------------------------------------
package rvcx_pkg;

  typedef struct packed {
    logic [31:0] word;
    logic        illegal;
  } rvcx_result_t;

  localparam logic [31:0] ILLEGAL_WORD = 32'hFFFF_FFFF;
  localparam logic [31:0] EBREAK_WORD  = 32'h0010_0073;
  localparam logic [31:0] NOP_WORD     = 32'h0000_0013;

  localparam logic [6:0] OPC_LOAD      = 7'h03;
  localparam logic [6:0] OPC_LOAD_FP   = 7'h07;
  localparam logic [6:0] OPC_OP_IMM    = 7'h13;
  localparam logic [6:0] OPC_OP_IMM_32 = 7'h1B;
  localparam logic [6:0] OPC_STORE     = 7'h23;
  localparam logic [6:0] OPC_STORE_FP  = 7'h27;
  localparam logic [6:0] OPC_OP        = 7'h33;
  localparam logic [6:0] OPC_LUI       = 7'h37;
  localparam logic [6:0] OPC_OP_32     = 7'h3B;
  localparam logic [6:0] OPC_BRANCH    = 7'h63;
  localparam logic [6:0] OPC_JALR      = 7'h67;
  localparam logic [6:0] OPC_JAL       = 7'h6F;

  localparam logic [2:0] F3_ADD = 3'd0;
  localparam logic [2:0] F3_SLL = 3'd1;
  localparam logic [2:0] F3_W   = 3'd2;
  localparam logic [2:0] F3_D   = 3'd3;
  localparam logic [2:0] F3_XOR = 3'd4;
  localparam logic [2:0] F3_SR  = 3'd5;
  localparam logic [2:0] F3_OR  = 3'd6;
  localparam logic [2:0] F3_AND = 3'd7;

  localparam logic [6:0] F7_BASE = 7'h00;
  localparam logic [6:0] F7_SUB  = 7'h20;

  localparam logic [4:0] REG_ZERO = 5'd0;
  localparam logic [4:0] REG_RA   = 5'd1;
  localparam logic [4:0] REG_SP   = 5'd2;

  localparam logic [1:0] QUAD_0 = 2'd0;
  localparam logic [1:0] QUAD_1 = 2'd1;
  localparam logic [1:0] QUAD_2 = 2'd2;

  function automatic logic [31:0] enc_i(input logic [11:0] imm, input logic [4:0] rs1,
                                        input logic [2:0] f3, input logic [4:0] rd,
                                        input logic [6:0] opc);
    return {imm, rs1, f3, rd, opc};
  endfunction

  function automatic logic [31:0] enc_s(input logic [11:0] imm, input logic [4:0] rs2,
                                        input logic [4:0] rs1, input logic [2:0] f3,
                                        input logic [6:0] opc);
    return {imm[11:5], rs2, rs1, f3, imm[4:0], opc};
  endfunction

  function automatic logic [31:0] enc_r(input logic [6:0] f7, input logic [4:0] rs2,
                                        input logic [4:0] rs1, input logic [2:0] f3,
                                        input logic [4:0] rd, input logic [6:0] opc);
    return {f7, rs2, rs1, f3, rd, opc};
  endfunction

endpackage

FILE: rtl/rvcx_decode.sv
// ----------------------------------------------------------------------------
// rvcx_decode
// Combinational expansion of one compressed halfword into a 32-bit word.
// ----------------------------------------------------------------------------
module rvcx_decode (
  input  logic [15:0]           halfword,
  output rvcx_pkg::rvcx_result_t result
);
  import rvcx_pkg::*;

  localparam logic [2:0] C0_ADDI4SPN = 3'd0;
  localparam logic [2:0] C0_LW       = 3'd2;
  localparam logic [2:0] C0_LD       = 3'd3;
  localparam logic [2:0] C0_SW       = 3'd6;
  localparam logic [2:0] C0_SD       = 3'd7;

  localparam logic [2:0] C1_ADDI  = 3'd0;
  localparam logic [2:0] C1_ADDIW = 3'd1;
  localparam logic [2:0] C1_LI    = 3'd2;
  localparam logic [2:0] C1_LUI   = 3'd3;
  localparam logic [2:0] C1_MISC  = 3'd4;
  localparam logic [2:0] C1_J     = 3'd5;

  localparam logic [1:0] MISC_SRLI = 2'd0;
  localparam logic [1:0] MISC_SRAI = 2'd1;
  localparam logic [1:0] MISC_ANDI = 2'd2;

  localparam logic [1:0] ALU_SUB = 2'd0;
  localparam logic [1:0] ALU_XOR = 2'd1;
  localparam logic [1:0] ALU_OR  = 2'd2;

  localparam logic [2:0] C2_SLLI  = 3'd0;
  localparam logic [2:0] C2_FLDSP = 3'd1;
  localparam logic [2:0] C2_LWSP  = 3'd2;
  localparam logic [2:0] C2_LDSP  = 3'd3;
  localparam logic [2:0] C2_JR    = 3'd4;
  localparam logic [2:0] C2_FSDSP = 3'd5;
  localparam logic [2:0] C2_SWSP  = 3'd6;

  logic [15:0] h;
  logic [2:0]  g;
  logic [4:0]  plo, phi, full, low5;
  logic        top;
  logic [11:0] s6, sa;
  logic [11:0] wofs, dofs;
  logic [31:0] word;
  logic        bad;

  assign h    = halfword;
  assign g    = h[15:13];
  assign plo  = {2'b01, h[4:2]};
  assign phi  = {2'b01, h[9:7]};
  assign full = h[11:7];
  assign low5 = h[6:2];
  assign top  = h[12];
  assign s6   = {{7{top}}, low5};
  assign sa   = {6'b0, top, low5};
  assign wofs = {5'b0, h[5], h[12:10], h[6], 2'b00};
  assign dofs = {4'b0, h[6:5], h[12:10], 3'b000};

  always_comb begin
    word = ILLEGAL_WORD;
    bad  = 1'b0;
    case (h[1:0])
      QUAD_0: begin
        case (g)
          C0_ADDI4SPN: begin
            if (h == 16'h0000) begin
              bad = 1'b1;
            end else begin
              word = enc_i({2'b00, h[10:7], h[12:11], h[5], h[6], 2'b00},
                           REG_SP, F3_ADD, plo, OPC_OP_IMM);
            end
          end
          C0_LW:   word = enc_i(wofs, phi, F3_W, plo, OPC_LOAD);
          C0_LD:   word = enc_i(dofs, phi, F3_D, plo, OPC_LOAD);
          C0_SW:   word = enc_s(wofs, plo, phi, F3_W, OPC_STORE);
          C0_SD:   word = enc_s(dofs, plo, phi, F3_D, OPC_STORE);
          default: bad = 1'b1;
        endcase
      end
      QUAD_1: begin
        case (g)
          C1_ADDI: begin
            if (full == REG_ZERO) begin
              word = NOP_WORD;
            end else begin
              word = enc_i(s6, full, F3_ADD, full, OPC_OP_IMM);
            end
          end
          C1_ADDIW: word = enc_i(s6, full, F3_ADD, full, OPC_OP_IMM_32);
          C1_LI:    word = enc_i(s6, REG_ZERO, F3_ADD, full, OPC_OP_IMM);
          C1_LUI: begin
            if (full == REG_SP) begin
              word = enc_i({{3{top}}, h[4:3], h[5], h[2], h[6], 4'b0000},
                           REG_SP, F3_ADD, REG_SP, OPC_OP_IMM);
            end else begin
              word = {{15{top}}, low5, full, OPC_LUI};
            end
          end
          C1_MISC: begin
            case (h[11:10])
              MISC_SRLI: word = enc_i(sa, phi, F3_SR, phi, OPC_OP_IMM);
              MISC_SRAI: word = enc_i(sa | 12'h400, phi, F3_SR, phi, OPC_OP_IMM);
              MISC_ANDI: word = enc_i(s6, phi, F3_AND, phi, OPC_OP_IMM);
              default: begin
                if (top) begin
                  case (h[6:5])
                    ALU_SUB: word = enc_r(F7_SUB, plo, phi, F3_ADD, phi, OPC_OP_32);
                    ALU_XOR: word = enc_r(F7_BASE, plo, phi, F3_ADD, phi, OPC_OP_32);
                    default: bad = 1'b1;
                  endcase
                end else begin
                  case (h[6:5])
                    ALU_SUB: word = enc_r(F7_SUB, plo, phi, F3_ADD, phi, OPC_OP);
                    ALU_XOR: word = enc_r(F7_BASE, plo, phi, F3_XOR, phi, OPC_OP);
                    ALU_OR:  word = enc_r(F7_BASE, plo, phi, F3_OR, phi, OPC_OP);
                    default: word = enc_r(F7_BASE, plo, phi, F3_AND, phi, OPC_OP);
                  endcase
                end
              end
            endcase
          end
          C1_J: begin
            word = {top, h[8], h[10:9], h[6], h[7], h[2], h[11], h[5:3],
                    top, {8{top}}, REG_ZERO, OPC_JAL};
          end
          default: begin
            word = {top, {3{top}}, h[6:5], h[2], REG_ZERO, phi, 2'b00, g[0],
                    h[11:10], h[4:3], top, OPC_BRANCH};
          end
        endcase
      end
      QUAD_2: begin
        case (g)
          C2_SLLI:  word = enc_i(sa, full, F3_SLL, full, OPC_OP_IMM);
          C2_FLDSP: word = enc_i({3'b000, h[4:2], top, h[6:5], 3'b000},
                                 REG_SP, F3_D, full, OPC_LOAD_FP);
          C2_LDSP:  word = enc_i({3'b000, h[4:2], top, h[6:5], 3'b000},
                                 REG_SP, F3_D, full, OPC_LOAD);
          C2_LWSP:  word = enc_i({4'b0000, h[3:2], top, h[6:4], 2'b00},
                                 REG_SP, F3_W, full, OPC_LOAD);
          C2_JR: begin
            if (!top) begin
              if (low5 == REG_ZERO) begin
                word = enc_i(12'h000, full, F3_ADD, REG_ZERO, OPC_JALR);
              end else begin
                word = enc_r(F7_BASE, low5, REG_ZERO, F3_ADD, full, OPC_OP);
              end
            end else if (low5 != REG_ZERO) begin
              word = enc_r(F7_BASE, low5, full, F3_ADD, full, OPC_OP);
            end else if (full == REG_ZERO) begin
              word = EBREAK_WORD;
            end else begin
              word = enc_i(12'h000, full, F3_ADD, REG_RA, OPC_JALR);
            end
          end
          C2_FSDSP: word = enc_s({3'b000, h[9:7], h[12:10], 3'b000},
                                 low5, REG_SP, F3_D, OPC_STORE_FP);
          C2_SWSP:  word = enc_s({4'b0000, h[8:7], h[12:9], 2'b00},
                                 low5, REG_SP, F3_W, OPC_STORE);
          default:  word = enc_s({3'b000, h[9:7], h[12:10], 3'b000},
                                 low5, REG_SP, F3_D, OPC_STORE);
        endcase
      end
      default: bad = 1'b1;
    endcase
    if (bad) begin
      word = ILLEGAL_WORD;
    end
  end

  assign result.word    = word;
  assign result.illegal = bad;

endmodule

FILE: rtl/rv64c_instruction_expander.sv
// ----------------------------------------------------------------------------
// rv64c_instruction_expander
// Expands RV64C compressed halfwords into 32-bit RV64I/D instruction words.
// ----------------------------------------------------------------------------
// One transaction per clock sustained while out_stall is low. Each halfword
// lands in an input register, is expanded by the combinational decoder, and
// is captured in the output register whenever out_stall does not hold it.
// out_stall holds a valid output register and, when the input register is
// also occupied, is passed back combinationally as in_stall. Illegal
// encodings return 0xFFFFFFFF with out_illegal set. No state is kept
// between transactions.
module rv64c_instruction_expander (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] in_halfword,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_expanded_word,
  output logic        out_illegal
);
  import rvcx_pkg::*;

  logic         s1_valid_r, s1_valid_nxt;
  logic [15:0]  s1_half_r;
  logic         out_valid_r, out_valid_nxt;
  rvcx_result_t out_res_r;
  rvcx_result_t dec_res;
  logic         s1_adv;
  logic         in_take;

  rvcx_decode u_decode (
    .halfword (s1_half_r),
    .result   (dec_res)
  );

  assign s1_adv   = !out_valid_r || !out_stall;
  assign in_stall = s1_valid_r && !s1_adv;
  assign in_take  = in_valid && !in_stall;

  assign s1_valid_nxt  = in_take ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_r);
  assign out_valid_nxt = s1_adv ? s1_valid_r : out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_half_r <= in_halfword;
    end
    if (s1_adv && s1_valid_r) begin
      out_res_r <= dec_res;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_expanded_word = out_res_r.word;
  assign out_illegal       = out_res_r.illegal;

  a_illegal_word: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_res_r.illegal) |-> (out_res_r.word == ILLEGAL_WORD))
    else $error("illegal result without all-ones word");

  a_legal_opcode: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_res_r.illegal) |-> (out_res_r.word[1:0] == 2'b11))
    else $error("expanded word is not a 32-bit encoding");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && out_valid_r && out_stall))
    else $error("input stalled without a full pipeline");

  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s1_adv) |=> s1_valid_r)
    else $error("pending transaction dropped from input register");

endmodule
